/* rtl/lcp_pkg.sv */
// Package for the line command parser: command codes, word phase type and
// the keyword tables used by the per-byte matcher.
// No dependencies.
package lcp_pkg;

	// Command codes reported on each line feed
	localparam logic [2:0] CMD_NONE    = 3'd0;
	localparam logic [2:0] CMD_START   = 3'd1;
	localparam logic [2:0] CMD_STOP    = 3'd2;
	localparam logic [2:0] CMD_STATUS  = 3'd3;
	localparam logic [2:0] CMD_HELP    = 3'd4;
	localparam logic [2:0] CMD_INVALID = 3'd5;

	// Character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TILDE = 8'h7E;

	// Default maximum number of characters per line
	localparam int LINE_LIMIT_DEF = 32;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_WORD,
		PH_AFTER
	} phase_t;

	// Keyword lengths: start, stop, status, help
	function automatic logic [2:0] kw_len(input logic [1:0] k);
		logic [2:0] len;
		unique case (k)
			2'd0: len = 3'd5;
			2'd1: len = 3'd4;
			2'd2: len = 3'd6;
			2'd3: len = 3'd4;
			default: len = 3'd0;
		endcase
		return len;
	endfunction

	// Keyword text, one character per position
	function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] pos);
		logic [7:0] ch;
		case ({k, pos})
			{2'd0, 3'd0}: ch = "s";
			{2'd0, 3'd1}: ch = "t";
			{2'd0, 3'd2}: ch = "a";
			{2'd0, 3'd3}: ch = "r";
			{2'd0, 3'd4}: ch = "t";
			{2'd1, 3'd0}: ch = "s";
			{2'd1, 3'd1}: ch = "t";
			{2'd1, 3'd2}: ch = "o";
			{2'd1, 3'd3}: ch = "p";
			{2'd2, 3'd0}: ch = "s";
			{2'd2, 3'd1}: ch = "t";
			{2'd2, 3'd2}: ch = "a";
			{2'd2, 3'd3}: ch = "t";
			{2'd2, 3'd4}: ch = "u";
			{2'd2, 3'd5}: ch = "s";
			{2'd3, 3'd0}: ch = "h";
			{2'd3, 3'd1}: ch = "e";
			{2'd3, 3'd2}: ch = "l";
			{2'd3, 3'd3}: ch = "p";
			default:      ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* rtl/line_command_parser.sv */
// The command code of each accepted byte is registered in the output register.
// Throughput: one byte per cycle while in_stall is low; the next-state and match logic is a single pass.
// Input is stalled only while the output register holds a code that is stalled.
// Reset (arst_n low, asynchronous): line state clears to an empty line, output empty.
// Line parser top level: byte filter, incremental keyword matcher, output register.
// Depends on lcp_pkg.
module line_command_parser #(
	parameter int LINE_LIMIT = lcp_pkg::LINE_LIMIT_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] command_code
);
	import lcp_pkg::*;

	localparam logic [5:0] LIMIT = 6'(LINE_LIMIT);

	logic [5:0] char_count_q, char_count_d;
	logic       bad_line_q, bad_line_d;
	logic       saw_cr_q, saw_cr_d;
	phase_t     phase_q, phase_d;
	logic [2:0] word_pos_q, word_pos_d;
	logic [3:0] cands_q, cands_d;
	logic [2:0] code_d;
	logic [2:0] code_q;
	logic       out_valid_q;
	logic       accept;
	logic       blank;
	logic       printable;
	logic [3:0] cands_match;
	logic [2:0] word_pos_inc;
	logic [2:0] verdict;

	assign in_stall     = out_valid_q & out_stall;
	assign accept       = in_valid & ~in_stall;
	assign out_valid    = out_valid_q;
	assign command_code = code_q;

	assign blank     = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB);
	assign printable = (rx_byte == CH_TAB) || ((rx_byte >= CH_SPACE) && (rx_byte <= CH_TILDE));

	// Drop keywords that no longer match at this position
	always_comb begin
		cands_match = cands_q;
		for (int k = 0; k < 4; k++) begin
			if (word_pos_q >= kw_len(2'(k)) || kw_char(2'(k), word_pos_q) != rx_byte) begin
				cands_match[k] = 1'b0;
			end
		end
		word_pos_inc = (word_pos_q == 3'd7) ? word_pos_q : word_pos_q + 3'd1;
	end

	// Line verdict; lowest keyword index wins
	always_comb begin
		verdict = CMD_INVALID;
		for (int k = 3; k >= 0; k--) begin
			if (cands_q[k] && word_pos_q == kw_len(2'(k))) begin
				verdict = 3'(k + 1);
			end
		end
		if (bad_line_q) begin
			verdict = CMD_INVALID;
		end else if (phase_q == PH_LEAD) begin
			verdict = CMD_NONE;
		end
	end

	// Next line state and code for this byte
	always_comb begin
		char_count_d = char_count_q;
		bad_line_d   = bad_line_q;
		saw_cr_d     = saw_cr_q;
		phase_d      = phase_q;
		word_pos_d   = word_pos_q;
		cands_d      = cands_q;
		code_d       = CMD_NONE;
		if (rx_byte == CH_LF) begin
			code_d       = verdict;
			char_count_d = '0;
			bad_line_d   = 1'b0;
			saw_cr_d     = 1'b0;
			phase_d      = PH_LEAD;
			word_pos_d   = '0;
			cands_d      = 4'hF;
		end else if (bad_line_q) begin
			// ignore the rest of a bad line
		end else if (saw_cr_q) begin
			bad_line_d = 1'b1;
		end else if (rx_byte == CH_CR) begin
			saw_cr_d = 1'b1;
		end else if (char_count_q >= LIMIT || !printable) begin
			bad_line_d = 1'b1;
		end else begin
			char_count_d = char_count_q + 6'd1;
			case (phase_q)
				PH_LEAD: begin
					if (!blank) begin
						phase_d    = PH_WORD;
						cands_d    = cands_match;
						word_pos_d = word_pos_inc;
					end
				end
				PH_WORD: begin
					if (blank) begin
						phase_d = PH_AFTER;
					end else begin
						cands_d    = cands_match;
						word_pos_d = word_pos_inc;
					end
				end
				default: begin
					if (!blank) begin
						cands_d = 4'h0;
					end
				end
			endcase
		end
	end

	// Line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q <= '0;
			bad_line_q   <= 1'b0;
			saw_cr_q     <= 1'b0;
			phase_q      <= PH_LEAD;
			word_pos_q   <= '0;
			cands_q      <= 4'hF;
		end else if (accept) begin
			char_count_q <= char_count_d;
			bad_line_q   <= bad_line_d;
			saw_cr_q     <= saw_cr_d;
			phase_q      <= phase_d;
			word_pos_q   <= word_pos_d;
			cands_q      <= cands_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= code_d;
		end
	end

`ifndef SYNTH
	// Only a line feed can produce a code other than none
	a_none_off_lf: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rx_byte != CH_LF |=> out_valid && command_code == CMD_NONE)
		else $error("non-none code for a byte other than line feed");

	// A line feed returns the line state to empty
	a_lf_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && rx_byte == CH_LF |=> char_count_q == 6'd0 && !bad_line_q && !saw_cr_q
		&& cands_q == 4'hF)
		else $error("line state not cleared after line feed");

	// No word position before the word has started
	a_lead_pos: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_LEAD |-> word_pos_q == 3'd0)
		else $error("word position advanced during leading blanks");

	// Character count never passes the line limit
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		char_count_q <= LIMIT)
		else $error("character count above line limit");
`endif

endmodule

/* sim/line_command_parser_checker.sv */
// Checker for the line command parser: watches both channels, predicts the
// command code of every accepted byte and compares it with the output.
// Depends on lcp_pkg.
module line_command_parser_checker #(
	parameter int LINE_LIMIT = lcp_pkg::LINE_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  command_code,
	output int unsigned mismatch_count,
	output int unsigned codes_outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import lcp_pkg::*;

	// Keyword list, in code order
	string      keywords [4]     = '{"start", "stop", "status", "help"};
	logic [2:0] keyword_code [4] = '{CMD_START, CMD_STOP, CMD_STATUS, CMD_HELP};

	// Line state of the predictor
	logic [5:0] line_chars;
	logic       line_bad;
	logic       cr_seen;
	phase_t     word_state;
	logic [2:0] word_len;
	logic [3:0] live_keywords;

	// Codes predicted but not yet seen on the output, oldest first
	logic [2:0] pending_codes [$];
	logic [2:0] expected_code;

	function automatic void clear_line();
		line_chars    = '0;
		line_bad      = 1'b0;
		cr_seen       = 1'b0;
		word_state    = PH_LEAD;
		word_len      = '0;
		live_keywords = 4'hF;
	endfunction

	// Drop every keyword that disagrees with this word character
	function automatic void match_keywords(input logic [7:0] ch);
		for (int k = 0; k < 4; k++) begin
			if (live_keywords[k] &&
			    (word_len >= keywords[k].len() || keywords[k][word_len] != ch))
				live_keywords[k] = 1'b0;
		end
		if (word_len < 3'd7)
			word_len = word_len + 3'd1;
	endfunction

	// Advance the line state by one byte and return its command code
	function automatic logic [2:0] parse_byte(input logic [7:0] ch);
		logic [2:0] code;
		logic       blank;
		code  = CMD_NONE;
		blank = (ch == CH_SPACE) || (ch == CH_TAB);
		if (ch == CH_LF) begin
			if (line_bad) begin
				code = CMD_INVALID;
			end else if (word_state != PH_LEAD) begin
				code = CMD_INVALID;
				for (int k = 3; k >= 0; k--) begin
					if (live_keywords[k] && word_len == keywords[k].len())
						code = keyword_code[k];
				end
			end
			clear_line();
		end else if (!line_bad) begin
			if (cr_seen) begin
				// anything but a line feed after a carriage return spoils the line
				line_bad = 1'b1;
			end else if (ch == CH_CR) begin
				cr_seen = 1'b1;
			end else if (line_chars >= LINE_LIMIT ||
			             (ch != CH_TAB && (ch < CH_SPACE || ch > CH_TILDE))) begin
				line_bad = 1'b1;
			end else begin
				line_chars = line_chars + 6'd1;
				case (word_state)
					PH_LEAD: begin
						if (!blank) begin
							word_state = PH_WORD;
							match_keywords(ch);
						end
					end
					PH_WORD: begin
						if (blank)
							word_state = PH_AFTER;
						else
							match_keywords(ch);
					end
					default: begin
						// text after trailing blanks kills every keyword
						if (!blank)
							live_keywords = '0;
					end
				endcase
			end
		end
		return code;
	endfunction

	// Compare output transactions first, then predict the accepted input byte
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			pending_codes.delete();
			mismatch_count    = 0;
			codes_outstanding = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (pending_codes.size() == 0) begin
					mismatch_count++;
					$display("%0t: command_code expected no transaction, got %0d",
					         $time, command_code);
				end else begin
					expected_code = pending_codes.pop_front();
					if (command_code !== expected_code) begin
						mismatch_count++;
						$display("%0t: command_code expected %0d, got %0d",
						         $time, expected_code, command_code);
					end
				end
			end
			if (in_valid && !in_stall)
				pending_codes.push_back(parse_byte(rx_byte));
			codes_outstanding = pending_codes.size();
		end
	end

endmodule

/* sim/line_command_parser_tb.sv */
// Testbench top for the line command parser: drives console lines into the
// block, randomizes idling on both sides and reports the verdict.
// Depends on lcp_pkg, line_command_parser and line_command_parser_checker.
module line_command_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import lcp_pkg::*;

	localparam int LIMIT       = LINE_LIMIT_DEF;
	localparam int BYTE_TARGET = 1750;
	localparam int HOLD_CYCLES = 80;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_stall;
	logic [2:0] command_code;

	int unsigned mismatch_count;
	int unsigned codes_outstanding;

	bit  idle_on;
	int  hold_requests;
	int  holds_done;
	int  bytes_sent;

	string      keywords [4] = '{"start", "stop", "status", "help"};
	logic [7:0] line_buf [$];

	always #10 clk = ~clk;

	line_command_parser #(
		.LINE_LIMIT(LIMIT)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.command_code (command_code)
	);

	line_command_parser_checker #(
		.LINE_LIMIT(LIMIT)
	) u_checker (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_stall          (in_stall),
		.rx_byte           (rx_byte),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.command_code      (command_code),
		.mismatch_count    (mismatch_count),
		.codes_outstanding (codes_outstanding)
	);

	function automatic void queue_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endfunction

	function automatic void add_blanks(input int n);
		repeat (n) line_buf.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
	endfunction

	// One random console line, always closed by a line feed
	function automatic void build_line();
		int kind;
		int k;
		int variant;
		int total;
		int lead;
		int n;
		kind = $urandom_range(0, 19);
		k    = $urandom_range(0, 3);
		if (kind <= 10) begin
			// keyword, possibly mangled, with blanks around it
			add_blanks($urandom_range(0, 3));
			queue_text(keywords[k]);
			variant = $urandom_range(0, 5);
			if (variant == 3)
				void'(line_buf.pop_back());
			else if (variant == 4)
				line_buf.push_back(8'($urandom_range(8'h61, 8'h7A)));
			else if (variant == 5)
				line_buf[line_buf.size() - 1 - $urandom_range(0, keywords[k].len() - 1)] =
					8'($urandom_range(8'h61, 8'h7A));
			add_blanks($urandom_range(0, 3));
			if ($urandom_range(0, 5) == 0) begin
				add_blanks(1);
				line_buf.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
			end
			if ($urandom_range(0, 2) == 0)
				line_buf.push_back(CH_CR);
		end else if (kind <= 13) begin
			// padded keyword right around the line limit
			total = $urandom_range(LIMIT - 2, LIMIT + 2);
			lead  = $urandom_range(0, total - keywords[k].len());
			add_blanks(lead);
			queue_text(keywords[k]);
			add_blanks(total - keywords[k].len() - lead);
			if ($urandom_range(0, 1) == 0)
				line_buf.push_back(CH_CR);
		end else if (kind <= 15) begin
			// free printable text or blanks only
			n = $urandom_range(1, 12);
			if ($urandom_range(0, 3) == 0) begin
				add_blanks(n);
			end else begin
				repeat (n) begin
					if ($urandom_range(0, 7) == 0)
						line_buf.push_back(CH_TAB);
					else
						line_buf.push_back(8'($urandom_range(CH_SPACE, CH_TILDE)));
				end
			end
			if ($urandom_range(0, 2) == 0)
				line_buf.push_back(CH_CR);
		end else if (kind <= 17) begin
			// carriage return followed by a random byte, which may itself be a line feed
			queue_text(keywords[k]);
			line_buf.push_back(CH_CR);
			line_buf.push_back(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 1) == 0)
				queue_text(keywords[$urandom_range(0, 3)]);
		end else begin
			// raw byte noise
			n = $urandom_range(1, 6);
			repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
		end
		line_buf.push_back(CH_LF);
	endfunction

	// Offer one byte, with an optional idle burst before it
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 7) == 0)
			gap = $urandom_range(1, 17);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_line();
		foreach (line_buf[i])
			send_byte(line_buf[i]);
		line_buf.delete();
	endtask

	// Stop offering until every predicted code has come out
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (codes_outstanding != 0);
		@(posedge clk);
	endtask

	// Sender: reset, directed lines, random lines, verdict
	initial begin
		bit hold_issued;
		bit pause_done;
		hold_issued = 1'b0;
		pause_done  = 1'b0;
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		rx_byte    <= '0;
		idle_on     = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: every keyword, blanks, CR before LF, empty line,
		// double CR, text after trailing blank, byte extremes
		line_buf.push_back(CH_TAB);
		queue_text("stop ");
		line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
		queue_text(" start");
		line_buf.push_back(CH_LF);
		queue_text("status");
		line_buf.push_back(CH_LF);
		queue_text("help x");
		line_buf.push_back(CH_LF);
		line_buf.push_back(CH_LF);
		line_buf.push_back(CH_CR);
		line_buf.push_back(CH_CR);
		line_buf.push_back(CH_LF);
		line_buf.push_back(8'h00);
		line_buf.push_back(8'hFF);
		line_buf.push_back(CH_LF);
		send_line();
		drain();

		// random lines; idling off in every third segment and at the end
		while (bytes_sent < BYTE_TARGET) begin
			idle_on = (bytes_sent < BYTE_TARGET - 250) && ((bytes_sent / 150) % 3 != 2);
			if (!hold_issued && bytes_sent >= 600) begin
				hold_requests++;
				hold_issued = 1'b1;
			end
			if (!pause_done && bytes_sent >= 1100) begin
				drain();
				pause_done = 1'b1;
			end
			build_line();
			send_line();
		end
		drain();
		repeat (4) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: random stall bursts plus one long hold on request
	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_requests > holds_done) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				holds_done++;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog
	initial begin
		#(10_000_000);
		$display("Mismatches found");
		$finish;
	end

endmodule

/* files.f */
rtl/lcp_pkg.sv
rtl/line_command_parser.sv
sim/line_command_parser_checker.sv
sim/line_command_parser_tb.sv
